/* rtl/core/bmhq_pkg.sv */
`default_nettype none
package bmhq_pkg;

  // request operation codes
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // result error codes
  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_EMPTY = 2'd1;
  localparam logic [1:0] ERR_FULL  = 2'd2;

  // widest key the datapath handles
  localparam int WIDE_W = 64;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_UP      = 5'b00010,
    ST_DN_LOAD = 5'b00100,
    ST_DN      = 5'b01000,
    ST_DONE    = 5'b10000
  } state_t;

endpackage
`default_nettype wire

/* rtl/core/bmhq_ifs.sv */
`default_nettype none
// request channel: one enqueue or dequeue per request
interface bmhq_cmd_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink (input valid, input command, input value, output ready);
endinterface

// result channel: heap status after each request
interface bmhq_res_if #(
  parameter int CNT_W = 7
);
  logic             valid;
  logic             ready;
  logic [31:0]      max_value;
  logic [CNT_W-1:0] count;
  logic             empty_res;
  logic [1:0]       error;

  modport source (output valid, output max_value, output count, output empty_res,
                  output error, input ready);
  modport sink (input valid, input max_value, input count, input empty_res,
                input error, output ready);
endinterface
`default_nettype wire

/* rtl/core/binary_max_heap_queue.sv */
// Order: a full enqueue, or a dequeue on an empty heap or of the last entry, goes straight to DONE;
// an enqueue loops in UP while the key climbs, a dequeue passes DN_LOAD, then loops in DN while it sinks.
// Requests: one at a time; a new one is taken only in IDLE, once the last result has been taken;
// each level step writes the single-write, dual-read heap memory once.
// Reset: synchronous, clears the entry count, sequencer and result valid; the heap memory
// is not cleared, as only entries below the count are ever used.
`default_nettype none
module binary_max_heap_queue import bmhq_pkg::*; #(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 32
) (
  input  wire        clk,
  input  wire        rst,
  bmhq_cmd_if.sink   cmd_ch,
  bmhq_res_if.source res_ch
);

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IW    = AW + 2;

  // heap memory and its ports
  logic [KEY_WIDTH-1:0] heap_mem [CAPACITY];
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [KEY_WIDTH-1:0] wdata;
  logic [AW-1:0]        ra0;
  logic [AW-1:0]        ra1;
  logic [KEY_WIDTH-1:0] rd0;
  logic [KEY_WIDTH-1:0] rd1;

  // sequencer registers
  state_t               state, state_next;
  logic [CNT_W-1:0]     count, count_next;
  logic [AW-1:0]        k, k_next;
  logic [AW-1:0]        node, node_next;
  logic [KEY_WIDTH-1:0] key, key_next;
  logic [1:0]           err, err_next;
  logic [KEY_WIDTH-1:0] root;

  // result register
  logic                 res_valid;
  logic [31:0]          res_max;
  logic [CNT_W-1:0]     res_count;
  logic                 res_empty;
  logic [1:0]           res_err;

  logic                 cmd_fire;
  logic [WIDE_W-1:0]    value_ext;
  logic [WIDE_W-1:0]    root_ext;
  logic [KEY_WIDTH-1:0] key_in;
  logic [IW-1:0]        left_i;
  logic [IW-1:0]        right_i;
  logic [IW-1:0]        cnt_i;
  logic [IW-1:0]        child_i;
  logic [IW-1:0]        child_l;
  logic [IW-1:0]        child_r;
  logic                 pick_right;
  logic [KEY_WIDTH-1:0] child_val;

  function automatic logic [AW-1:0] parent_of(input logic [AW-1:0] idx);
    logic [AW-1:0] dec;
    dec = idx - AW'(1);
    return dec >> 1;
  endfunction

  assign cmd_fire      = cmd_ch.valid && cmd_ch.ready;
  assign cmd_ch.ready  = (state == ST_IDLE) && (!res_valid || res_ch.ready);
  assign value_ext     = {{(WIDE_W-32){1'b0}}, cmd_ch.value};
  assign key_in        = value_ext[KEY_WIDTH-1:0];
  assign root_ext      = WIDE_W'(root);

  // child indices of the sinking node, kept wide so they never wrap
  assign left_i     = (IW'(node) << 1) + IW'(1);
  assign right_i    = left_i + IW'(1);
  assign cnt_i      = IW'(count);
  assign pick_right = (right_i < cnt_i) && (rd1 > rd0);
  assign child_val  = pick_right ? rd1 : rd0;
  assign child_i    = pick_right ? right_i : left_i;
  assign child_l    = (child_i << 1) + IW'(1);
  assign child_r    = child_l + IW'(1);

  // sequencer
  always_comb begin
    state_next = state;
    count_next = count;
    k_next     = k;
    node_next  = node;
    key_next   = key;
    err_next   = err;
    we         = 1'b0;
    waddr      = k;
    wdata      = key;
    ra0        = '0;
    ra1        = '0;
    case (state)
      ST_IDLE: begin
        if (cmd_fire) begin
          state_next = ST_DONE;
          err_next   = ERR_OK;
          if (cmd_ch.command == CMD_DEQ) begin
            if (count == '0) begin
              err_next = ERR_EMPTY;
            end else begin
              count_next = count - CNT_W'(1);
              if (count != CNT_W'(1)) begin
                ra0        = AW'(count - CNT_W'(1));
                state_next = ST_DN_LOAD;
              end
            end
          end else if (count == CNT_W'(CAPACITY)) begin
            err_next = ERR_FULL;
          end else begin
            key_next   = key_in;
            k_next     = AW'(count);
            count_next = count + CNT_W'(1);
            ra0        = parent_of(AW'(count));
            state_next = ST_UP;
          end
        end
      end
      ST_UP: begin
        // rd0 holds the parent of slot k
        we = 1'b1;
        if (k == '0 || !(key > rd0)) begin
          waddr      = k;
          wdata      = key;
          state_next = ST_DONE;
        end else begin
          waddr  = k;
          wdata  = rd0;
          k_next = parent_of(k);
          ra0    = parent_of(parent_of(k));
        end
      end
      ST_DN_LOAD: begin
        // last entry becomes the sinking key, root children are fetched
        key_next   = rd0;
        node_next  = '0;
        ra0        = AW'(1);
        ra1        = AW'(2);
        state_next = ST_DN;
      end
      ST_DN: begin
        we    = 1'b1;
        waddr = node;
        if (left_i >= cnt_i || !(key < child_val)) begin
          wdata      = key;
          state_next = ST_DONE;
        end else begin
          wdata     = child_val;
          node_next = AW'(child_i);
          ra0       = AW'(child_l);
          ra1       = AW'(child_r);
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    k    <= k_next;
    node <= node_next;
    key  <= key_next;
    err  <= err_next;
  end

  // heap memory, one write and two registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      heap_mem[waddr] <= wdata;
    end
    rd0 <= heap_mem[ra0];
    rd1 <= heap_mem[ra1];
  end

  // shadow copy of the root slot
  always_ff @(posedge clk) begin
    if (we && waddr == '0) begin
      root <= wdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ST_DONE) begin
      res_valid <= 1'b1;
    end else if (res_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE) begin
      res_max   <= (count != '0) ? root_ext[31:0] : 32'd0;
      res_count <= count;
      res_empty <= (count == '0);
      res_err   <= err;
    end
  end

  assign res_ch.valid     = res_valid;
  assign res_ch.max_value = res_max;
  assign res_ch.count     = res_count;
  assign res_ch.empty_res = res_empty;
  assign res_ch.error     = res_err;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_res_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == ST_DONE))
    else $error("result raised outside completion");

  a_deq_dec: assert property (@(posedge clk) disable iff (rst)
    cmd_fire && cmd_ch.command == CMD_DEQ && count != '0 |=> count == $past(count) - CNT_W'(1))
    else $error("dequeue did not drop the count");

  a_up_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_UP |-> CNT_W'(k) < count)
    else $error("sift-up slot outside the heap");

  a_dn_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_DN |-> CNT_W'(node) < count)
    else $error("sift-down slot outside the heap");

endmodule
`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps
`default_nettype none
module testbench import bmhq_pkg::*;;

  localparam int HEAP_DEPTH = 64;
  localparam int RANDOM_REQS = 1250;
  localparam int QUIET_FROM = 1080;
  localparam int DRAIN_CYCLES = 24;
  localparam int MAX_SHOWN = 10;

  // heap status as reported for one request
  typedef struct packed {
    logic [31:0] max_value;
    logic [6:0]  count;
    logic        empty_res;
    logic [1:0]  error;
  } heap_status_t;

  // one line of the directed sequence; key advances by step on each repeat
  typedef struct {
    logic        cmd;
    logic [31:0] key;
    logic [31:0] step;
    int          reps;
    bit          fixed;
    logic [31:0] max_value;
    logic [6:0]  count;
    logic        empty_res;
    logic [1:0]  error;
  } req_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bmhq_cmd_if cmd_ch ();
  bmhq_res_if #(.CNT_W(7)) res_ch ();

  binary_max_heap_queue #(
    .CAPACITY (HEAP_DEPTH),
    .KEY_WIDTH(32)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .cmd_ch(cmd_ch),
    .res_ch(res_ch)
  );

  always #5 clk = ~clk;

  // shadow heap and outstanding statuses
  logic [31:0]  heap_keys [0:HEAP_DEPTH-1];
  int           heap_len = 0;
  heap_status_t pending_status [$];
  int           error_count = 0;
  bit           quiet_phase = 1'b0;
  int           stall_left = 0;

  req_row_t dir_rows [0:16] = '{
    '{CMD_DEQ, 32'h0000_0000, 32'd0, 1,  1'b1, 32'h0000_0000, 7'd0,  1'b1, ERR_EMPTY},
    '{CMD_ENQ, 32'h0000_0000, 32'd0, 1,  1'b1, 32'h0000_0000, 7'd1,  1'b0, ERR_OK},
    '{CMD_DEQ, 32'hFFFF_FFFF, 32'd0, 1,  1'b1, 32'h0000_0000, 7'd0,  1'b1, ERR_OK},
    '{CMD_ENQ, 32'hFFFF_FFFF, 32'd0, 1,  1'b1, 32'hFFFF_FFFF, 7'd1,  1'b0, ERR_OK},
    '{CMD_ENQ, 32'h0000_0000, 32'd0, 1,  1'b1, 32'hFFFF_FFFF, 7'd2,  1'b0, ERR_OK},
    '{CMD_ENQ, 32'hFFFF_FFFF, 32'd0, 1,  1'b0, 32'h0, 7'd0, 1'b0, ERR_OK},
    '{CMD_ENQ, 32'h0000_0000, 32'd0, 1,  1'b0, 32'h0, 7'd0, 1'b0, ERR_OK},
    '{CMD_ENQ, 32'h8000_0000, 32'd0, 1,  1'b0, 32'h0, 7'd0, 1'b0, ERR_OK},
    '{CMD_ENQ, 32'h7FFF_FFFF, 32'd0, 1,  1'b0, 32'h0, 7'd0, 1'b0, ERR_OK},
    '{CMD_DEQ, 32'hA5A5_A5A5, 32'd0, 6,  1'b0, 32'h0, 7'd0, 1'b0, ERR_OK},
    '{CMD_DEQ, 32'h5A5A_5A5A, 32'd0, 1,  1'b1, 32'h0000_0000, 7'd0,  1'b1, ERR_EMPTY},
    '{CMD_ENQ, 32'h0000_1000, 32'd1, 64, 1'b0, 32'h0, 7'd0, 1'b0, ERR_OK},
    '{CMD_ENQ, 32'hFFFF_FFFF, 32'd0, 1,  1'b1, 32'h0000_103F, 7'd64, 1'b0, ERR_FULL},
    '{CMD_DEQ, 32'h0000_0000, 32'd0, 64, 1'b0, 32'h0, 7'd0, 1'b0, ERR_OK},
    '{CMD_DEQ, 32'hFFFF_FFFF, 32'd0, 1,  1'b1, 32'h0000_0000, 7'd0,  1'b1, ERR_EMPTY},
    '{CMD_ENQ, 32'h1234_5678, 32'd0, 5,  1'b0, 32'h0, 7'd0, 1'b0, ERR_OK},
    '{CMD_DEQ, 32'h0000_0000, 32'd0, 5,  1'b0, 32'h0, 7'd0, 1'b0, ERR_OK}
  };

  // apply one request to the shadow heap and return the status it leaves
  function automatic heap_status_t apply_request(input logic cmd, input logic [31:0] key);
    heap_status_t st;
    logic [1:0]   err;
    logic [31:0]  tmp;
    int           node;
    int           par;
    int           lc;
    int           pick;
    bit           settled;
    err = ERR_OK;
    settled = 1'b0;
    if (cmd == CMD_DEQ) begin
      if (heap_len == 0) begin
        err = ERR_EMPTY;
      end else begin
        // last entry to the root, then sink; right child only if strictly larger
        heap_len = heap_len - 1;
        heap_keys[0] = heap_keys[heap_len];
        node = 0;
        while (!settled) begin
          lc = 2 * node + 1;
          if (lc >= heap_len) begin
            settled = 1'b1;
          end else begin
            pick = lc;
            if (lc + 1 < heap_len && heap_keys[lc+1] > heap_keys[lc]) pick = lc + 1;
            if (heap_keys[node] < heap_keys[pick]) begin
              tmp = heap_keys[node];
              heap_keys[node] = heap_keys[pick];
              heap_keys[pick] = tmp;
              node = pick;
            end else begin
              settled = 1'b1;
            end
          end
        end
      end
    end else begin
      if (heap_len >= HEAP_DEPTH) begin
        err = ERR_FULL;
      end else begin
        // append, then climb while strictly above the parent
        heap_keys[heap_len] = key;
        node = heap_len;
        heap_len = heap_len + 1;
        while (node > 0 && !settled) begin
          par = (node - 1) / 2;
          if (heap_keys[node] > heap_keys[par]) begin
            tmp = heap_keys[node];
            heap_keys[node] = heap_keys[par];
            heap_keys[par] = tmp;
            node = par;
          end else begin
            settled = 1'b1;
          end
        end
      end
    end
    st.max_value = (heap_len > 0) ? heap_keys[0] : 32'd0;
    st.count     = 7'(heap_len);
    st.empty_res = (heap_len == 0);
    st.error     = err;
    return st;
  endfunction

  // present one request, wait for it to be taken, then record its status
  task automatic send_request(input logic cmd, input logic [31:0] key, input bit fixed,
                              input heap_status_t typed_status);
    heap_status_t st;
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.command <= cmd;
    cmd_ch.value   <= key;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    st = apply_request(cmd, key);
    pending_status = {pending_status, (fixed ? typed_status : st)};
  endtask

  // result side: random stall bursts and in-order status check
  always @(posedge clk) begin
    heap_status_t want;
    heap_status_t got;
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left = stall_left - 1;
      end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
        res_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 15);
      end else begin
        res_ch.ready <= 1'b1;
      end
      if (res_ch.valid && res_ch.ready) begin
        got = '{res_ch.max_value, res_ch.count, res_ch.empty_res, res_ch.error};
        if (pending_status.size() == 0) begin
          error_count = error_count + 1;
          if (error_count <= MAX_SHOWN)
            $display("%0t: unexpected status max %h count %0d empty %b error %0d", $realtime,
                     got.max_value, got.count, got.empty_res, got.error);
        end else begin
          want = pending_status.pop_front();
          if (got.max_value !== want.max_value || got.count !== want.count ||
              got.empty_res !== want.empty_res || got.error !== want.error) begin
            error_count = error_count + 1;
            if (error_count <= MAX_SHOWN)
              $display("%0t: status mismatch: expected %h %0d %b %0d, got %h %0d %b %0d",
                       $realtime, want.max_value, want.count, want.empty_res, want.error,
                       got.max_value, got.count, got.empty_res, got.error);
          end
        end
      end
    end
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // stimulus
  initial begin
    heap_status_t typed;
    logic         cmd;
    logic [31:0]  key;
    int           mode;
    int           seg_left;
    int           enq_pct;
    int           pick;
    cmd_ch.valid   <= 1'b0;
    cmd_ch.command <= CMD_ENQ;
    cmd_ch.value   <= 32'd0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed sequence
    foreach (dir_rows[r]) begin
      typed = '{dir_rows[r].max_value, dir_rows[r].count, dir_rows[r].empty_res,
                dir_rows[r].error};
      for (int i = 0; i < dir_rows[r].reps; i++)
        send_request(dir_rows[r].cmd, dir_rows[r].key + 32'(i) * dir_rows[r].step,
                     dir_rows[r].fixed, typed);
    end

    // random sequence: fill, drain and mixed stretches sweep the count end to end
    seg_left = 0;
    enq_pct = 50;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n == QUIET_FROM) quiet_phase <= 1'b1;
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 120);
        mode = $urandom_range(0, 2);
        enq_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
      end
      seg_left = seg_left - 1;
      cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
      pick = $urandom_range(0, 9);
      if (cmd == CMD_DEQ || pick < 5) key = $urandom;
      else if (pick < 8) key = 32'($urandom_range(0, 7));
      else if (pick == 8) key = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
      else key = 32'hFFFF_FFF0 | 32'($urandom_range(0, 15));
      send_request(cmd, key, 1'b0, '0);
    end
    cmd_ch.valid <= 1'b0;

    // drain outstanding statuses, then watch for strays
    while (pending_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* sim.f */
rtl/core/bmhq_pkg.sv
rtl/core/bmhq_ifs.sv
rtl/core/binary_max_heap_queue.sv
dv/testbench.sv
